// ===== sv/kehs_pkg.sv =====
package kehs_pkg;

    // field widths
    localparam int LEVEL_W = 10;
    localparam int TIME_W  = 32;
    localparam int QUERY_W = 4;
    localparam int HOLD_W  = 16;
    localparam int NPK_W   = 4;

    // reset values
    localparam logic [LEVEL_W-1:0] PRIOR_RESET   = 10'h3FF;
    localparam logic [HOLD_W-1:0]  HOLD_MS_RESET = 16'd600;

    // one result word
    typedef struct packed {
        logic [LEVEL_W-1:0] pressed_mask;
        logic               any_change;
        logic               new_press_valid;
        logic [NPK_W-1:0]   new_press_key;
        logic               key_pressed;
        logic               key_rose;
        logic               key_fell;
        logic               key_held;
    } result_t;

endpackage

// ===== sv/key_edge_and_hold_scanner.sv =====
// key edge and hold scanner
// a word in the input register moves to the result register once the output is free
// throughput: one word per cycle while the output is not stalled; input register, key logic, result register
// in_stall rises only when both stages hold words and the output is stalled
// reset (rst_n, async, active low): pipeline empty, hold_ms = 600,
// all keys taken as pressed before the first word, no press start times valid
module key_edge_and_hold_scanner #(
    parameter int NUM_KEYS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // hold time register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kehs_pkg::HOLD_W-1:0]       hold_ms,

    // input words
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [kehs_pkg::LEVEL_W-1:0]      key_levels,
    input  logic [kehs_pkg::TIME_W-1:0]       now_ms,
    input  logic [kehs_pkg::QUERY_W-1:0]      query_key,

    // result words
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [kehs_pkg::LEVEL_W-1:0]      pressed_mask,
    output logic                              any_change,
    output logic                              new_press_valid,
    output logic [kehs_pkg::NPK_W-1:0]        new_press_key,
    output logic                              key_pressed,
    output logic                              key_rose,
    output logic                              key_fell,
    output logic                              key_held
);

    // index width for the key set
    localparam int KIW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    // working mask width: at least the level field
    localparam int MW  = (NUM_KEYS > kehs_pkg::LEVEL_W) ? NUM_KEYS : kehs_pkg::LEVEL_W;
    localparam logic [MW-1:0] ALL_W = MW'((64'd1 << NUM_KEYS) - 64'd1);
    localparam logic [MW-1:0] PRIOR_INIT_W = MW'(kehs_pkg::PRIOR_RESET) & ALL_W;

    // configuration
    logic [kehs_pkg::HOLD_W-1:0]  hold_ms_reg;

    // input stage
    logic                         s1_valid_reg;
    logic [kehs_pkg::LEVEL_W-1:0] s1_levels_reg;
    logic [kehs_pkg::TIME_W-1:0]  s1_now_reg;
    logic [kehs_pkg::QUERY_W-1:0] s1_query_reg;

    // key state
    logic [NUM_KEYS-1:0]          prior_reg;
    logic [NUM_KEYS-1:0]          prior_next;
    logic [NUM_KEYS-1:0]          start_valid_reg;
    logic [NUM_KEYS-1:0]          start_valid_next;
    logic [kehs_pkg::TIME_W-1:0]  press_start_reg [NUM_KEYS];

    // result stage
    logic                         out_valid_reg;
    kehs_pkg::result_t            result_reg;
    kehs_pkg::result_t            result_next;

    // handshake
    logic                         out_free;
    logic                         s1_fire;
    logic                         in_take;

    // key logic
    logic [MW-1:0]                levels_w;
    logic [MW-1:0]                cur_w;
    logic [MW-1:0]                prev_w;
    logic [MW-1:0]                rising_w;
    logic [NUM_KEYS-1:0]          cur;
    logic [NUM_KEYS-1:0]          rising;
    logic                         np_valid;
    logic [KIW-1:0]               np_key;
    logic [7:0]                   np_key_w;
    logic [5:0]                   query_w;
    logic                         q_in_range;
    logic [KIW-1:0]               q_idx;
    logic [kehs_pkg::TIME_W-1:0]  start_time;
    logic [kehs_pkg::TIME_W-1:0]  elapsed;
    logic                         q_down;

    // a result moves out when the output register is empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_fire   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_ms_reg <= kehs_pkg::HOLD_MS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            hold_ms_reg <= hold_ms;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_levels_reg <= key_levels;
            s1_now_reg    <= now_ms;
            s1_query_reg  <= query_key;
        end
    end

    // pressed mask: active-low pins, keys past the level field read as pressed
    always_comb
    begin
        levels_w = MW'(s1_levels_reg);
        cur_w    = ~levels_w & ALL_W;
        prev_w   = MW'(prior_reg);
        rising_w = cur_w & ~prev_w;
        cur      = cur_w[NUM_KEYS-1:0];
        rising   = rising_w[NUM_KEYS-1:0];
    end

    // lowest newly pressed key
    always_comb
    begin
        np_valid = |rising;
        np_key   = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (rising[i])
            begin
                np_key = KIW'(i);
            end
        end
        np_key_w = 8'(np_key);
    end

    // queried key; a press starting this word counts from now
    always_comb
    begin
        query_w    = 6'(s1_query_reg);
        q_in_range = query_w < 6'(NUM_KEYS);
        q_idx      = query_w[KIW-1:0];
        q_down     = q_in_range && cur[q_idx];
        start_time = start_valid_reg[q_idx] ? press_start_reg[q_idx] : s1_now_reg;
        elapsed    = s1_now_reg - start_time;
    end

    always_comb
    begin
        result_next.pressed_mask    = cur_w[kehs_pkg::LEVEL_W-1:0];
        result_next.any_change      = cur_w != prev_w;
        result_next.new_press_valid = np_valid;
        result_next.new_press_key   = np_key_w[kehs_pkg::NPK_W-1:0];
        result_next.key_pressed     = q_down;
        result_next.key_rose        = q_in_range && rising[q_idx];
        result_next.key_fell        = q_in_range && !cur[q_idx] && prior_reg[q_idx];
        result_next.key_held        = q_down &&
            (elapsed >= {{(kehs_pkg::TIME_W - kehs_pkg::HOLD_W){1'b0}}, hold_ms_reg});
    end

    // start times follow the pressed mask: set on first down, dropped on release
    always_comb
    begin
        prior_next       = cur;
        start_valid_next = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_reg       <= PRIOR_INIT_W[NUM_KEYS-1:0];
            start_valid_reg <= '0;
        end
        else if (s1_fire)
        begin
            prior_reg       <= prior_next;
            start_valid_reg <= start_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (s1_fire && cur[i] && !start_valid_reg[i])
            begin
                press_start_reg[i] <= s1_now_reg;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pressed_mask    = result_reg.pressed_mask;
    assign any_change      = result_reg.any_change;
    assign new_press_valid = result_reg.new_press_valid;
    assign new_press_key   = result_reg.new_press_key;
    assign key_pressed     = result_reg.key_pressed;
    assign key_rose        = result_reg.key_rose;
    assign key_fell        = result_reg.key_fell;
    assign key_held        = result_reg.key_held;

endmodule

// ===== sv/kehs_checker.sv =====
module kehs_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [kehs_pkg::HOLD_W-1:0]       hold_ms,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [kehs_pkg::LEVEL_W-1:0]      key_levels,
    input  logic [kehs_pkg::TIME_W-1:0]       now_ms,
    input  logic [kehs_pkg::QUERY_W-1:0]      query_key,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [kehs_pkg::LEVEL_W-1:0]      pressed_mask,
    input  logic                              any_change,
    input  logic                              new_press_valid,
    input  logic [kehs_pkg::NPK_W-1:0]        new_press_key,
    input  logic                              key_pressed,
    input  logic                              key_rose,
    input  logic                              key_fell,
    input  logic                              key_held
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pressed_mask) &&
        $stable(new_press_key) && $stable(key_held) && $stable(any_change))
        else $error("result word changed while stalled");

    // no new press means key index zero
    a_npk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !new_press_valid |-> new_press_key == '0)
        else $error("new press key set without a new press");

    // edges agree with the current level of the queried key
    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(key_rose && !key_pressed) && !(key_fell && key_pressed) &&
        !(key_held && !key_pressed))
        else $error("queried key flags disagree with key_pressed");

    // a rising queried key is a new press and a change
    a_rose_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_rose |-> new_press_valid && any_change)
        else $error("queried key rose without a new press");

    // a release of the queried key changes the mask
    a_fell_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_fell |-> any_change)
        else $error("queried key fell without a mask change");

endmodule

bind key_edge_and_hold_scanner kehs_checker u_kehs_checker (.*);

// ===== dv/tb_key_edge_and_hold_scanner.sv =====
`timescale 1ns / 1ps

module tb_key_edge_and_hold_scanner;

    localparam int KEYS         = 10;
    localparam int PHASES       = 5;
    localparam int WORDS_EACH   = 170;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES  = 4;      // margin after the last result leaves the block

    // clock and reset
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // hold time register port
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [kehs_pkg::HOLD_W-1:0] hold_ms   = '0;

    // input words
    logic                         in_valid   = 1'b0;
    logic                         in_stall;
    logic [kehs_pkg::LEVEL_W-1:0] key_levels = '1;
    logic [kehs_pkg::TIME_W-1:0]  now_ms     = '0;
    logic [kehs_pkg::QUERY_W-1:0] query_key  = '0;

    // result words
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [kehs_pkg::LEVEL_W-1:0] pressed_mask;
    logic                         any_change;
    logic                         new_press_valid;
    logic [kehs_pkg::NPK_W-1:0]   new_press_key;
    logic                         key_pressed;
    logic                         key_rose;
    logic                         key_fell;
    logic                         key_held;

    // sideband travelling with the offered word: a typed-in expectation, if any
    logic              word_has_typed = 1'b0;
    kehs_pkg::result_t word_typed     = '0;

    key_edge_and_hold_scanner DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .hold_ms         (hold_ms),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .key_levels      (key_levels),
        .now_ms          (now_ms),
        .query_key       (query_key),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pressed_mask    (pressed_mask),
        .any_change      (any_change),
        .new_press_valid (new_press_valid),
        .new_press_key   (new_press_key),
        .key_pressed     (key_pressed),
        .key_rose        (key_rose),
        .key_fell        (key_fell),
        .key_held        (key_held)
    );

    // ------------------------------------------------------------------
    // scan predictor: own copy of the key state and the hold register
    // ------------------------------------------------------------------
    // every key taken as down at reset
    logic [kehs_pkg::LEVEL_W-1:0] scan_prior    = kehs_pkg::PRIOR_RESET;
    logic [kehs_pkg::TIME_W-1:0]  scan_start[KEYS];
    logic [KEYS-1:0]              scan_start_ok = '0;
    logic [kehs_pkg::HOLD_W-1:0]  scan_hold     = kehs_pkg::HOLD_MS_RESET;

    function automatic kehs_pkg::result_t predict_scan(
        input logic [kehs_pkg::LEVEL_W-1:0] lv,
        input logic [kehs_pkg::TIME_W-1:0]  t,
        input logic [kehs_pkg::QUERY_W-1:0] q);
        logic [kehs_pkg::LEVEL_W-1:0] cur;
        logic [kehs_pkg::LEVEL_W-1:0] rising;
        logic [kehs_pkg::TIME_W-1:0]  age;
        kehs_pkg::result_t            r;
        int                           i;
        cur    = ~lv;
        rising = cur & ~scan_prior;
        // a press start is stamped on the first down tick and dropped on release
        for (i = 0; i < KEYS; i++)
        begin
            if (cur[i])
            begin
                if (!scan_start_ok[i])
                begin
                    scan_start[i]    = t;
                    scan_start_ok[i] = 1'b1;
                end
            end
            else
                scan_start_ok[i] = 1'b0;
        end
        r                 = '0;
        r.pressed_mask    = cur;
        r.any_change      = (cur != scan_prior);
        // walk downwards so the lowest new press wins
        for (i = KEYS - 1; i >= 0; i--)
        begin
            if (rising[i])
            begin
                r.new_press_valid = 1'b1;
                r.new_press_key   = kehs_pkg::NPK_W'(i);
            end
        end
        // queries beyond the last key leave all four flags low
        if (q < KEYS)
        begin
            age           = t - scan_start[q];   // wraps like the 32-bit counter
            r.key_pressed = cur[q];
            r.key_rose    = rising[q];
            r.key_fell    = !cur[q] && scan_prior[q];
            r.key_held    = cur[q] && scan_start_ok[q] && (age >= {16'b0, scan_hold});
        end
        scan_prior = cur;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking and handshake watchdog
    // ------------------------------------------------------------------
    kehs_pkg::result_t pending_scans[$];
    int      n_errors   = 0;
    int      n_words    = 0;
    int      n_results  = 0;
    int      n_holds    = 0;
    int      n_held     = 0;
    int      n_off_keys = 0;
    int      quiet      = 0;

    task automatic check_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        kehs_pkg::result_t want;
        logic              moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                n_results++;
                if (key_held === 1'b1)
                    n_held++;
                if (pending_scans.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    n_errors++;
                end
                else
                begin
                    want = pending_scans.pop_front();
                    check_field("pressed_mask", 32'(want.pressed_mask), 32'(pressed_mask));
                    check_field("any_change", 32'(want.any_change), 32'(any_change));
                    check_field("new_press_valid", 32'(want.new_press_valid),
                                32'(new_press_valid));
                    check_field("new_press_key", 32'(want.new_press_key),
                                32'(new_press_key));
                    check_field("key_pressed", 32'(want.key_pressed), 32'(key_pressed));
                    check_field("key_rose", 32'(want.key_rose), 32'(key_rose));
                    check_field("key_fell", 32'(want.key_fell), 32'(key_fell));
                    check_field("key_held", 32'(want.key_held), 32'(key_held));
                end
            end
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                n_words++;
                if (query_key >= KEYS)
                    n_off_keys++;
                // the predictor always runs so its state stays in step
                want = predict_scan(key_levels, now_ms, query_key);
                if (word_has_typed)
                    pending_scans.push_back(word_typed);
                else
                    pending_scans.push_back(want);
            end
            if (cfg_valid && cfg_ready)
            begin
                moved     = 1'b1;
                scan_hold = hold_ms;
                n_holds++;
            end
            if (moved)
                quiet = 0;
            else
            begin
                quiet++;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, a long hold-off that backs the block up,
    // and a stretch with no stalls at all, counted in its own cycles
    // ------------------------------------------------------------------
    initial
    begin
        int cyc;
        int pos;
        cyc = 0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            cyc++;
            pos = cyc % 1000;
            if (pos >= 300 && pos < 370)
                out_stall <= 1'b1;                         // hold off, input must fill and stall
            else if (pos >= 500 && pos < 800)
                out_stall <= 1'b0;                         // free running
            else
                out_stall <= ($urandom_range(0, 99) < 28);
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    typedef struct {
        logic [kehs_pkg::LEVEL_W-1:0] lv;
        logic [kehs_pkg::TIME_W-1:0]  t;
        logic [kehs_pkg::QUERY_W-1:0] q;
        logic                         has_typed;
        kehs_pkg::result_t            typed;
    } scan_row_t;

    scan_row_t dir_rows[$];
    logic      gaps_on = 1'b1;

    function automatic kehs_pkg::result_t mk_res(input logic [9:0] mask, input logic chg,
                                                 input logic npv, input logic [3:0] npk,
                                                 input logic down, input logic rose,
                                                 input logic fell, input logic held);
        kehs_pkg::result_t r;
        r.pressed_mask    = mask;
        r.any_change      = chg;
        r.new_press_valid = npv;
        r.new_press_key   = npk;
        r.key_pressed     = down;
        r.key_rose        = rose;
        r.key_fell        = fell;
        r.key_held        = held;
        return r;
    endfunction

    task automatic add_row(input logic [9:0] lv, input logic [31:0] t, input logic [3:0] q,
                           input logic has_typed, input kehs_pkg::result_t typed);
        scan_row_t row;
        row.lv        = lv;
        row.t         = t;
        row.q         = q;
        row.has_typed = has_typed;
        row.typed     = typed;
        dir_rows.push_back(row);
    endtask

    // offer one word and hold it until taken; valid is decided before stall is seen
    task automatic send_word(input logic [9:0] lv, input logic [31:0] t, input logic [3:0] q,
                             input logic has_typed, input kehs_pkg::result_t typed);
        while (gaps_on && $urandom_range(0, 99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        key_levels     <= lv;
        now_ms         <= t;
        query_key      <= q;
        word_has_typed <= has_typed;
        word_typed     <= typed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // one edge first so the last accepted word is already queued
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_scans.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold(input logic [15:0] v);
        cfg_valid <= 1'b1;
        hold_ms   <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] hold_set[PHASES];
        logic [9:0]  lv;
        logic [9:0]  flips;
        logic [31:0] t;
        logic [3:0]  q;
        int          p;
        int          k;
        int          b;

        // first tick after reset: keys 0-3 down are not new presses, key 9 up reads as fell
        add_row(10'h3F0, 32'd0,   4'd9,  1'b1,
                mk_res(10'h00F, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        // just short of and exactly at the reset hold time
        add_row(10'h3F0, 32'd599, 4'd2,  1'b1,
                mk_res(10'h00F, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b0));
        add_row(10'h3F0, 32'd600, 4'd2,  1'b1,
                mk_res(10'h00F, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1));
        // release and re-press of key 0
        add_row(10'h3F1, 32'd601, 4'd0,  1'b1,
                mk_res(10'h00E, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        add_row(10'h3F0, 32'd700, 4'd0,  1'b1,
                mk_res(10'h00F, 1'b1, 1'b1, 4'd0, 1'b1, 1'b1, 1'b0, 1'b0));
        add_row(10'h3F0, 32'd700, 4'd10, 1'b0, '0);
        // all down at the top of the time range, then all up
        add_row(10'h000, 32'hFFFF_FFFF, 4'd15, 1'b1,
                mk_res(10'h3FF, 1'b1, 1'b1, 4'd4, 1'b0, 1'b0, 1'b0, 1'b0));
        add_row(10'h3FF, 32'hFFFF_FFFF, 4'd0,  1'b1,
                mk_res(10'h000, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 1'b1, 1'b0));
        // highest key pressed just before the counter wraps, held across the wrap
        add_row(10'h1FF, 32'hFFFF_FF00, 4'd9,  1'b0, '0);
        add_row(10'h1FF, 32'h0000_0157, 4'd9,  1'b0, '0);
        add_row(10'h1FF, 32'h0000_0158, 4'd9,  1'b0, '0);
        // alternating patterns and out-of-range queries
        add_row(10'h2AA, 32'h0000_1000, 4'd8,  1'b0, '0);
        add_row(10'h155, 32'h0000_1001, 4'd1,  1'b0, '0);
        add_row(10'h155, 32'h0000_1002, 4'd11, 1'b0, '0);
        add_row(10'h155, 32'h0000_1003, 4'd13, 1'b0, '0);
        add_row(10'h3FE, 32'h0000_1004, 4'd14, 1'b0, '0);
        add_row(10'h3FE, 32'h8000_0000, 4'd15, 1'b0, '0);
        add_row(10'h000, 32'h8000_0258, 4'd0,  1'b0, '0);
        add_row(10'h000, 32'h8000_0259, 4'd7,  1'b0, '0);
        add_row(10'h3FF, 32'h0000_0000, 4'd5,  1'b0, '0);

        hold_set[0] = 16'd0;
        hold_set[1] = 16'hFFFF;
        hold_set[2] = 16'd1;
        hold_set[3] = 16'($urandom);
        hold_set[4] = 16'($urandom_range(100, 3000));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset hold time
        foreach (dir_rows[i])
            send_word(dir_rows[i].lv, dir_rows[i].t, dir_rows[i].q,
                      dir_rows[i].has_typed, dir_rows[i].typed);

        // random phases, one hold setting each, written only with the block empty
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_hold(hold_set[p]);
            gaps_on = (p != 2);
            if (p % 2)
                t = 32'hFFFF_FFFF - $urandom_range(0, 30000);   // run through the wrap
            else
                t = $urandom;
            lv = 10'h3FF;
            for (k = 0; k < WORDS_EACH; k++)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    // plausible key activity: a few keys move, time moves forward
                    flips = '0;
                    for (b = 0; b < KEYS; b++)
                        if ($urandom_range(0, 9) == 0)
                            flips[b] = 1'b1;
                    lv = lv ^ flips;
                    if ($urandom_range(0, 3) == 0)
                        t = t + $urandom_range(0, 2 * hold_set[p] + 10);
                    else
                        t = t + $urandom_range(0, 50);
                    q = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                    : 4'($urandom_range(0, KEYS - 1));
                    send_word(lv, t, q, 1'b0, '0);
                end
                else
                begin
                    // noise word: anything goes, time may jump backwards
                    lv = 10'($urandom);
                    send_word(lv, $urandom, 4'($urandom_range(0, 15)), 1'b0, '0);
                end
            end
        end

        drain_results();
        $display("%0d words scanned, %0d results checked, %0d hold settings written",
                 n_words, n_results, n_holds);
        $display("%0d results with a held key, %0d queries beyond the last key",
                 n_held, n_off_keys);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
